/* rtl/fpa_pkg.sv */
// Shared types and operation codes for the Q24.8 fixed-point ALU.
package fpa_pkg;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_MIN = 3'd4,
    OP_MAX = 3'd5,
    OP_INC = 3'd6,
    OP_DEC = 3'd7
  } op_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] result;
    logic               a_less;
    logic               a_equal;
    logic               a_greater;
    logic               divide_by_zero;
  } out_word_t;

endpackage

/* rtl/fixed_point_alu_q24_8.sv */
// Top level of the Q24.8 fixed-point ALU.
// Usage: drive in with start high; a word is taken at any edge where start
// is high and busy is low. busy is always low: the pipeline takes a new word
// every cycle. Each word gives one result word on out, marked by done for
// exactly one cycle, in input order.
// Every operation takes the same path through the pipeline (the bit-per-stage
// divider sets its length; other operations are delayed to match).
// Stages: capture and magnitude prep, the divider stages plus a registered
// 32x32 multiplier in parallel, sign fix, selection into the output register.
// Reset clears the valid bits so no done appears until words are taken.
// The receiver cannot stall; results are shown once and not held.
// Throughput: one word per cycle.
module fixed_point_alu_q24_8 #(
  parameter int FRACTION_BITS = 8,
  parameter int WORD_BITS     = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  fpa_pkg::in_word_t  in,
  output logic               busy,
  output logic               done,
  output fpa_pkg::out_word_t out
);

  localparam int NB  = WORD_BITS + FRACTION_BITS;
  localparam int LAT = NB + 1;

  assign busy = 1'b0;

  logic                        take;
  logic signed [WORD_BITS-1:0] a0, b0;
  assign take = start & ~busy;
  assign a0 = in.operand_a[WORD_BITS-1:0];
  assign b0 = in.operand_b[WORD_BITS-1:0];

  // stage 1: capture, prep
  logic                        v1;
  logic [2:0]                  m1;
  logic signed [WORD_BITS-1:0] a1, b1;
  logic [WORD_BITS-1:0]        nb1;
  logic                        neg1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= take;
    m1   <= in.mode;
    a1   <= a0;
    b1   <= b0;
    nb1  <= b0[WORD_BITS-1] ? WORD_BITS'(-b0) : WORD_BITS'(b0);
    neg1 <= a0[WORD_BITS-1] ^ b0[WORD_BITS-1];
  end

  // magnitude of a shifted left; computed from a1 in stage 1 register path
  logic [NB-1:0] numer;
  assign numer = a1[WORD_BITS-1] ? NB'(-($signed({a1, {FRACTION_BITS{1'b0}}})))
                                 : NB'({a1, {FRACTION_BITS{1'b0}}});

  logic [NB-1:0] quo;
  fpa_div #(.NUM_BITS(NB), .DEN_BITS(WORD_BITS)) u_div (
    .clk (clk),
    .num (numer),
    .den (nb1),
    .quo (quo)
  );

  // delay lines for control and operands; multiplier: register product, then delay line
  logic                        vd [LAT];
  logic [2:0]                  md [LAT];
  logic signed [WORD_BITS-1:0] ad [LAT];
  logic signed [WORD_BITS-1:0] bd [LAT];
  logic                        nd [LAT];
  logic signed [2*WORD_BITS-1:0] pd [LAT];

  always_ff @(posedge clk) begin
    if (rst) vd[0] <= 1'b0;
    else     vd[0] <= v1;
    md[0] <= m1;
    ad[0] <= a1;
    bd[0] <= b1;
    nd[0] <= neg1;
    pd[0] <= a1 * b1;
    for (int i = 1; i < LAT; i++) begin
      if (rst) vd[i] <= 1'b0;
      else     vd[i] <= vd[i-1];
      md[i] <= md[i-1];
      ad[i] <= ad[i-1];
      bd[i] <= bd[i-1];
      nd[i] <= nd[i-1];
      pd[i] <= pd[i-1];
    end
  end

  // stage after divider: sign fix (quo valid at index NB-1)
  localparam int K = NB - 1;
  logic [NB-1:0] qs;
  always_ff @(posedge clk) qs <= nd[K] ? NB'(-quo) : quo;

  // final select at index K+1
  localparam int F = K + 1;
  logic signed [WORD_BITS-1:0] a, b, res;
  logic [WORD_BITS-1:0] one;
  logic lt, eq, dz;
  assign a   = ad[F];
  assign b   = bd[F];
  assign one = WORD_BITS'(1) << FRACTION_BITS;
  assign lt  = a < b;
  assign eq  = a == b;

  always_comb begin
    dz  = 1'b0;
    res = '0;
    case (fpa_pkg::op_t'(md[F]))
      fpa_pkg::OP_ADD: res = a + b;
      fpa_pkg::OP_SUB: res = a - b;
      fpa_pkg::OP_MUL: res = WORD_BITS'(pd[F] >>> FRACTION_BITS);
      fpa_pkg::OP_DIV: begin
        if (b == '0) dz = 1'b1;
        else         res = WORD_BITS'(qs);
      end
      fpa_pkg::OP_MIN: res = (lt | eq) ? a : b;
      fpa_pkg::OP_MAX: res = lt ? b : a;
      fpa_pkg::OP_INC: res = a + $signed(one);
      default:         res = a - $signed(one);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= vd[F];
    out.result         <= 32'(res);
    out.a_less         <= lt;
    out.a_equal        <= eq;
    out.a_greater      <= ~lt & ~eq;
    out.divide_by_zero <= dz;
  end

endmodule

/* rtl/fpa_div.sv */
// Pipelined restoring divider: one quotient bit per stage, unsigned magnitudes.
module fpa_div #(
  parameter int NUM_BITS = 40,
  parameter int DEN_BITS = 32
) (
  input  logic                clk,
  input  logic [NUM_BITS-1:0] num,
  input  logic [DEN_BITS-1:0] den,
  output logic [NUM_BITS-1:0] quo
);

  localparam int RB = DEN_BITS + 1;

  logic [NUM_BITS-1:0] q   [NUM_BITS+1];
  logic [RB-1:0]       r   [NUM_BITS+1];
  logic [DEN_BITS-1:0] d   [NUM_BITS+1];

  assign q[0] = num;
  assign r[0] = '0;
  assign d[0] = den;

  for (genvar s = 0; s < NUM_BITS; s++) begin : g_stage
    logic [RB-1:0]       trial;
    logic [RB-1:0]       diff;
    logic [NUM_BITS-1:0] quot;
    logic [RB-1:0]       rem;
    logic [DEN_BITS-1:0] dvs;
    assign trial = {r[s][RB-2:0], q[s][NUM_BITS-1]};
    assign diff  = trial - {1'b0, d[s]};
    always_ff @(posedge clk) begin
      dvs <= d[s];
      if (!diff[RB-1]) begin
        rem  <= diff;
        quot <= {q[s][NUM_BITS-2:0], 1'b1};
      end else begin
        rem  <= trial;
        quot <= {q[s][NUM_BITS-2:0], 1'b0};
      end
    end
    assign q[s+1] = quot;
    assign r[s+1] = rem;
    assign d[s+1] = dvs;
  end

  assign quo = q[NUM_BITS];

endmodule
